>>> rtl/mse_pkg.sv
// Shared types, constants and address checks for the MIPS-I subset execute core.
// No dependencies; every other file imports this package.
package mse_pkg;

  localparam int unsigned MEM_WORDS = 4096;
  localparam int unsigned MemAw     = $clog2(MEM_WORDS);

  localparam logic [1:0] KIND_EXEC  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_SETPC = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_OVF   = 2'd1;
  localparam logic [1:0] ST_ADDR  = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_REGIMM  = 6'd1;
  localparam logic [5:0] OP_J       = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_BLEZ    = 6'd6;
  localparam logic [5:0] OP_BGTZ    = 6'd7;
  localparam logic [5:0] OP_ADDI    = 6'd8;
  localparam logic [5:0] OP_ADDIU   = 6'd9;
  localparam logic [5:0] OP_SLTI    = 6'd10;
  localparam logic [5:0] OP_SLTIU   = 6'd11;
  localparam logic [5:0] OP_ANDI    = 6'd12;
  localparam logic [5:0] OP_ORI     = 6'd13;
  localparam logic [5:0] OP_XORI    = 6'd14;
  localparam logic [5:0] OP_LUI     = 6'd15;
  localparam logic [5:0] OP_LB      = 6'd32;
  localparam logic [5:0] OP_LW      = 6'd35;
  localparam logic [5:0] OP_LBU     = 6'd36;
  localparam logic [5:0] OP_SB      = 6'd40;
  localparam logic [5:0] OP_SH      = 6'd41;
  localparam logic [5:0] OP_SW      = 6'd43;

  localparam logic [5:0] FN_SLL   = 6'd0;
  localparam logic [5:0] FN_SRL   = 6'd2;
  localparam logic [5:0] FN_SRA   = 6'd3;
  localparam logic [5:0] FN_SLLV  = 6'd4;
  localparam logic [5:0] FN_SRLV  = 6'd6;
  localparam logic [5:0] FN_JR    = 6'd8;
  localparam logic [5:0] FN_MFHI  = 6'd16;
  localparam logic [5:0] FN_MFLO  = 6'd18;
  localparam logic [5:0] FN_MULT  = 6'd24;
  localparam logic [5:0] FN_MULTU = 6'd25;
  localparam logic [5:0] FN_DIV   = 6'd26;
  localparam logic [5:0] FN_DIVU  = 6'd27;
  localparam logic [5:0] FN_ADD   = 6'd32;
  localparam logic [5:0] FN_ADDU  = 6'd33;
  localparam logic [5:0] FN_SUB   = 6'd34;
  localparam logic [5:0] FN_SUBU  = 6'd35;
  localparam logic [5:0] FN_AND   = 6'd36;
  localparam logic [5:0] FN_OR    = 6'd37;
  localparam logic [5:0] FN_XOR   = 6'd38;
  localparam logic [5:0] FN_SLT   = 6'd42;
  localparam logic [5:0] FN_SLTU  = 6'd43;

  localparam logic [4:0] RT_BLTZ   = 5'd0;
  localparam logic [4:0] RT_BGEZ   = 5'd1;
  localparam logic [4:0] RT_BLTZAL = 5'd16;
  localparam logic [4:0] RT_BGEZAL = 5'd17;
  localparam logic [4:0] REG_RA    = 5'd31;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] byte_address;
    logic [31:0] word_data;
  } mse_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] program_counter;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic [31:0] read_word;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
  } mse_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_EXEC, S_MEM, S_MDRUN, S_MDFIN,
    S_HREAD, S_HDATA, S_COMMIT
  } mse_state_e;

  typedef enum logic [1:0] {MRD_PC, MRD_EA, MRD_HOST} mse_mrd_e;

  typedef struct packed {
    logic     latch;
    logic     fetch;
    logic     decode;
    logic     exec;
    logic     mem;
    logic     md_step;
    logic     md_fin;
    logic     hdata;
    logic     commit;
    logic     mrd_en;
    mse_mrd_e mrd_sel;
  } mse_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       fetch_fault;
    logic       need_mem;
    logic       is_md;
    logic       md_done;
    logic       out_busy;
  } mse_sts_t;

  function automatic logic [1:0] in_range(input logic [31:0] addr);
    return (addr[31:2] < 30'(MEM_WORDS)) ? ST_OK : ST_RANGE;
  endfunction

  function automatic logic [1:0] word_check(input logic [31:0] addr);
    return (addr[1:0] != 2'd0) ? ST_ADDR : in_range(addr);
  endfunction

endpackage

>>> rtl/mse_ctrl.sv
// Sequencer of the execute core: steps each item through fetch, decode,
// execute, memory, multiply/divide, host read and commit. Depends on mse_pkg.
module mse_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  mse_pkg::mse_sts_t sts_i,
  output mse_pkg::mse_cmd_t cmd_o
);
  import mse_pkg::*;

  mse_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (sts_i.kind)
            KIND_EXEC: state_d = S_FETCH;
            KIND_READ: state_d = S_HREAD;
            default:   state_d = S_COMMIT;
          endcase
        end
      end
      S_FETCH:  state_d = sts_i.fetch_fault ? S_COMMIT : S_DECODE;
      S_DECODE: state_d = S_EXEC;
      S_EXEC: begin
        if (sts_i.need_mem)   state_d = S_MEM;
        else if (sts_i.is_md) state_d = S_MDRUN;
        else                  state_d = S_COMMIT;
      end
      S_MEM:   state_d = S_COMMIT;
      S_MDRUN: state_d = sts_i.md_done ? S_MDFIN : S_MDRUN;
      S_MDFIN: state_d = S_COMMIT;
      S_HREAD: state_d = S_HDATA;
      S_HDATA: state_d = S_COMMIT;
      S_COMMIT: if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o         = '0;
    cmd_o.mrd_sel = MRD_PC;
    case (state_q)
      S_IDLE:   cmd_o.latch = in_valid_i;
      S_FETCH: begin
        cmd_o.fetch  = 1'b1;
        cmd_o.mrd_en = 1'b1;
      end
      S_DECODE: cmd_o.decode = 1'b1;
      S_EXEC: begin
        cmd_o.exec    = 1'b1;
        cmd_o.mrd_en  = 1'b1;
        cmd_o.mrd_sel = MRD_EA;
      end
      S_MEM:   cmd_o.mem = 1'b1;
      S_MDRUN: cmd_o.md_step = 1'b1;
      S_MDFIN: cmd_o.md_fin = 1'b1;
      S_HREAD: begin
        cmd_o.mrd_en  = 1'b1;
        cmd_o.mrd_sel = MRD_HOST;
      end
      S_HDATA:  cmd_o.hdata = 1'b1;
      S_COMMIT: cmd_o.commit = !sts_i.out_busy;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.commit) out_valid_d = 1'b1;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/mse_dpath.sv
// Datapath of the execute core: register file, word memory, pc, HI/LO,
// instruction evaluation and a shift-add / restoring multiply-divide unit.
// Depends on mse_pkg; driven by mse_ctrl commands.
module mse_dpath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mse_pkg::mse_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  mse_pkg::mse_cmd_t cmd_i,
  output mse_pkg::mse_sts_t sts_o,
  output mse_pkg::mse_out_t out_data_o
);
  import mse_pkg::*;

  logic [31:0] mem_q [MEM_WORDS];
  logic [31:0] mem_rdata_q;
  logic [31:0] rf_q [32];
  logic [31:0] rf_vld_q;
  logic [31:0] rfa_q, rfb_q;
  logic        va_q, vb_q;

  logic [1:0]  kind_q;
  logic [31:0] addr_q;
  logic [31:0] pc_q, npc_q, hi_q, lo_q;
  logic [31:0] pc_d, npc_d;
  logic [31:0] ins_q, ea_q;

  logic [1:0]  st_q;
  logic        wr_q, tk_q, hold_q, mwr_q;
  logic [4:0]  wi_q;
  logic [31:0] wv_q, tg_q, rdword_q, mwdata_q;
  logic [MemAw-1:0] mwidx_q;
  mse_out_t    out_q;

  logic [32:0] md_hi_q;
  logic [31:0] md_lo_q, md_d_q;
  logic [4:0]  md_cnt_q;
  logic        md_div_q, md_sgn_q;

  // instruction fields
  logic [5:0]  op, fn;
  logic [4:0]  rs, rt, rd, sa;
  logic [31:0] a, b, imm, simm, ea, boff, jt, link;
  logic [31:0] add_r, sub_r, addi_r;

  assign op   = ins_q[31:26];
  assign rs   = ins_q[25:21];
  assign rt   = ins_q[20:16];
  assign rd   = ins_q[15:11];
  assign sa   = ins_q[10:6];
  assign fn   = ins_q[5:0];
  assign a    = va_q ? rfa_q : 32'd0;
  assign b    = vb_q ? rfb_q : 32'd0;
  assign imm  = {16'd0, ins_q[15:0]};
  assign simm = {{16{ins_q[15]}}, ins_q[15:0]};
  assign ea   = a + simm;
  assign boff = npc_q + {simm[29:0], 2'b00};
  assign jt   = {npc_q[31:28], ins_q[25:0], 2'b00};
  assign link = pc_q + 32'd8;
  assign add_r  = a + b;
  assign sub_r  = a - b;
  assign addi_r = a + simm;

  logic [1:0]  x_st;
  logic        x_wr, x_tk, x_hold, x_mem, x_md;
  logic [4:0]  x_wi;
  logic [31:0] x_wv, x_tg;

  always_comb begin
    x_st = ST_OK; x_wr = 1'b0; x_wi = rd; x_wv = 32'd0;
    x_tk = 1'b0; x_tg = boff; x_hold = 1'b0; x_mem = 1'b0; x_md = 1'b0;
    case (op)
      OP_SPECIAL: begin
        case (fn)
          FN_SLL:  begin x_wr = 1'b1; x_wv = b << sa; end
          FN_SRL:  begin x_wr = 1'b1; x_wv = b >> sa; end
          FN_SRA:  begin x_wr = 1'b1; x_wv = 32'($signed(b) >>> sa); end
          FN_SLLV: begin x_wr = 1'b1; x_wv = b << a[4:0]; end
          FN_SRLV: begin x_wr = 1'b1; x_wv = b >> a[4:0]; end
          FN_JR: begin
            if (a[1:0] != 2'd0) x_st = ST_ADDR;
            else begin x_tk = 1'b1; x_tg = a; end
          end
          FN_MFHI: begin x_wr = 1'b1; x_wv = hi_q; end
          FN_MFLO: begin x_wr = 1'b1; x_wv = lo_q; end
          FN_MULT, FN_MULTU: x_md = 1'b1;
          FN_DIV, FN_DIVU:   x_md = (b != 32'd0);
          FN_ADD: begin
            if ((~(a ^ b) & (a ^ add_r)) >> 31 != 32'd0) x_st = ST_OVF;
            else begin x_wr = 1'b1; x_wv = add_r; end
          end
          FN_SUB: begin
            if (((a ^ b) & (a ^ sub_r)) >> 31 != 32'd0) x_st = ST_OVF;
            else begin x_wr = 1'b1; x_wv = sub_r; end
          end
          FN_ADDU: begin x_wr = 1'b1; x_wv = add_r; end
          FN_SUBU: begin x_wr = 1'b1; x_wv = sub_r; end
          FN_AND:  begin x_wr = 1'b1; x_wv = a & b; end
          FN_OR:   begin x_wr = 1'b1; x_wv = a | b; end
          FN_XOR:  begin x_wr = 1'b1; x_wv = a ^ b; end
          FN_SLT:  begin x_wr = 1'b1; x_wv = {31'd0, $signed(a) < $signed(b)}; end
          FN_SLTU: begin x_wr = 1'b1; x_wv = {31'd0, a < b}; end
          default: ;
        endcase
      end
      OP_REGIMM: begin
        if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
          x_wr = 1'b1; x_wi = REG_RA; x_wv = link;
        end
        if (rt == RT_BLTZ || rt == RT_BLTZAL) x_tk = a[31];
        else if (rt == RT_BGEZ || rt == RT_BGEZAL) x_tk = !a[31];
      end
      OP_J: begin x_tk = 1'b1; x_tg = jt; end
      OP_JAL: begin
        x_tk = 1'b1; x_tg = jt; x_wr = 1'b1; x_wi = REG_RA; x_wv = link;
      end
      OP_BEQ:  x_tk = (a == b);
      OP_BNE:  x_tk = (a != b);
      OP_BLEZ: x_tk = a[31] || (a == 32'd0);
      OP_BGTZ: x_tk = !a[31] && (a != 32'd0);
      OP_ADDI: begin
        x_wi = rt;
        if ((~(a ^ simm) & (a ^ addi_r)) >> 31 != 32'd0) x_st = ST_OVF;
        else begin x_wr = 1'b1; x_wv = addi_r; end
      end
      OP_ADDIU: begin x_wr = 1'b1; x_wi = rt; x_wv = addi_r; end
      OP_SLTI:  begin x_wr = 1'b1; x_wi = rt; x_wv = {31'd0, $signed(a) < $signed(simm)}; end
      OP_SLTIU: begin x_wr = 1'b1; x_wi = rt; x_wv = {31'd0, a < simm}; end
      OP_ANDI:  begin x_wr = 1'b1; x_wi = rt; x_wv = a & imm; end
      OP_ORI:   begin x_wr = 1'b1; x_wi = rt; x_wv = a | imm; end
      OP_XORI:  begin x_wr = 1'b1; x_wi = rt; x_wv = a ^ imm; end
      OP_LUI:   begin x_wr = 1'b1; x_wi = rt; x_wv = {ins_q[15:0], 16'd0}; end
      OP_LW: begin
        x_st = word_check(ea); x_wr = 1'b1; x_wi = rt; x_mem = (x_st == ST_OK);
      end
      OP_LB, OP_LBU: begin
        x_st = in_range(ea); x_wr = 1'b1; x_wi = rt; x_mem = (x_st == ST_OK);
      end
      OP_SW: begin
        x_st = word_check(ea); x_hold = (x_st == ST_ADDR); x_mem = (x_st == ST_OK);
      end
      OP_SB: begin
        x_st = in_range(ea); x_mem = (x_st == ST_OK);
      end
      OP_SH: begin
        if (ea[0]) begin x_st = ST_ADDR; x_hold = 1'b1; end
        else x_st = in_range(ea);
        x_mem = (x_st == ST_OK);
      end
      default: ;
    endcase
    x_wr = x_wr && (x_st == ST_OK) && (x_wi != 5'd0);
  end

  // memory
  logic [MemAw-1:0] mrd_idx;
  always_comb begin
    case (cmd_i.mrd_sel)
      MRD_EA:   mrd_idx = ea[MemAw+1:2];
      MRD_HOST: mrd_idx = addr_q[MemAw+1:2];
      default:  mrd_idx = pc_q[MemAw+1:2];
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mrd_en) mem_rdata_q <= mem_q[mrd_idx];
    if (cmd_i.commit && mwr_q) mem_q[mwidx_q] <= mwdata_q;
  end

  // register file
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && wr_q) rf_q[wi_q] <= wv_q;
    if (cmd_i.decode) begin
      rfa_q <= rf_q[mem_rdata_q[25:21]];
      rfb_q <= rf_q[mem_rdata_q[20:16]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_vld_q <= '0;
      va_q     <= 1'b0;
      vb_q     <= 1'b0;
    end else begin
      if (cmd_i.commit && wr_q) rf_vld_q[wi_q] <= 1'b1;
      if (cmd_i.decode) begin
        va_q <= rf_vld_q[mem_rdata_q[25:21]];
        vb_q <= rf_vld_q[mem_rdata_q[20:16]];
      end
    end
  end

  // load data and store merge
  logic [7:0]  ld_byte;
  logic [31:0] ld_val, st_word;
  always_comb begin
    case (ea_q[1:0])
      2'd0:    ld_byte = mem_rdata_q[31:24];
      2'd1:    ld_byte = mem_rdata_q[23:16];
      2'd2:    ld_byte = mem_rdata_q[15:8];
      default: ld_byte = mem_rdata_q[7:0];
    endcase
    ld_val  = (op == OP_LW) ? mem_rdata_q
            : (op == OP_LB) ? {{24{ld_byte[7]}}, ld_byte} : {24'd0, ld_byte};
    st_word = mem_rdata_q;
    case (op)
      OP_SB: begin
        case (ea_q[1:0])
          2'd0:    st_word[31:24] = b[7:0];
          2'd1:    st_word[23:16] = b[7:0];
          2'd2:    st_word[15:8]  = b[7:0];
          default: st_word[7:0]   = b[7:0];
        endcase
      end
      OP_SH: begin
        if (ea_q[1]) st_word[15:0] = b[15:0];
        else st_word[31:16] = b[15:0];
      end
      default: st_word = b;
    endcase
  end

  // multiply / divide unit
  logic [31:0] ma, mb;
  logic [32:0] md_sum, md_rsh;
  logic [33:0] md_diff;
  logic [31:0] corr_a, corr_b, q_fix, m_fix;
  assign ma      = (fn == FN_DIV && a[31]) ? 32'd0 - a : a;
  assign mb      = (fn == FN_DIV && b[31]) ? 32'd0 - b : b;
  assign md_sum  = {1'b0, md_hi_q[31:0]} + (md_lo_q[0] ? {1'b0, md_d_q} : 33'd0);
  assign md_rsh  = {md_hi_q[31:0], md_lo_q[31]};
  assign md_diff = {1'b0, md_rsh} - {2'b00, md_d_q};
  assign corr_a  = (md_sgn_q && a[31]) ? b : 32'd0;
  assign corr_b  = (md_sgn_q && b[31]) ? a : 32'd0;
  assign q_fix   = (md_sgn_q && (a[31] ^ b[31])) ? 32'd0 - md_lo_q : md_lo_q;
  assign m_fix   = (md_sgn_q && a[31]) ? 32'd0 - md_hi_q[31:0] : md_hi_q[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      md_div_q <= (fn == FN_DIV) || (fn == FN_DIVU);
      md_sgn_q <= (fn == FN_DIV) || (fn == FN_MULT);
      md_hi_q  <= '0;
      md_lo_q  <= (fn == FN_DIV || fn == FN_DIVU) ? ma : b;
      md_d_q   <= (fn == FN_DIV || fn == FN_DIVU) ? mb : a;
    end else if (cmd_i.md_step) begin
      if (md_div_q) begin
        if (!md_diff[33]) begin
          md_hi_q <= md_diff[32:0];
          md_lo_q <= {md_lo_q[30:0], 1'b1};
        end else begin
          md_hi_q <= md_rsh;
          md_lo_q <= {md_lo_q[30:0], 1'b0};
        end
      end else begin
        md_hi_q <= {1'b0, md_sum[32:1]};
        md_lo_q <= {md_sum[0], md_lo_q[31:1]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_cnt_q <= '0;
    end else if (cmd_i.exec) begin
      md_cnt_q <= '0;
    end else if (cmd_i.md_step) begin
      md_cnt_q <= md_cnt_q + 5'd1;
    end
  end

  // architectural state
  always_comb begin
    pc_d  = pc_q;
    npc_d = npc_q;
    if (kind_q == KIND_SETPC) begin
      pc_d  = addr_q;
      npc_d = addr_q + 32'd4;
    end else if (kind_q == KIND_EXEC && !hold_q) begin
      pc_d  = npc_q;
      npc_d = tk_q ? tg_q : npc_q + 32'd4;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= 32'd0;
      npc_q <= 32'd4;
      hi_q  <= 32'd0;
      lo_q  <= 32'd0;
    end else begin
      if (cmd_i.commit) begin
        pc_q  <= pc_d;
        npc_q <= npc_d;
      end
      if (cmd_i.md_fin) begin
        if (md_div_q) begin
          hi_q <= m_fix;
          lo_q <= q_fix;
        end else begin
          hi_q <= md_hi_q[31:0] - corr_a - corr_b;
          lo_q <= md_lo_q;
        end
      end
    end
  end

  // per-item result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q   <= in_data_i.kind;
      addr_q   <= in_data_i.byte_address;
      st_q     <= (in_data_i.kind == KIND_WRITE || in_data_i.kind == KIND_READ)
                  ? word_check(in_data_i.byte_address) : ST_OK;
      mwr_q    <= (in_data_i.kind == KIND_WRITE)
                  && (word_check(in_data_i.byte_address) == ST_OK);
      mwdata_q <= in_data_i.word_data;
      mwidx_q  <= in_data_i.byte_address[MemAw+1:2];
      hold_q   <= 1'b1;
      wr_q     <= 1'b0;
      wi_q     <= '0;
      wv_q     <= '0;
      tk_q     <= 1'b0;
      tg_q     <= '0;
      rdword_q <= '0;
    end
    if (cmd_i.fetch) begin
      st_q   <= word_check(pc_q);
      hold_q <= 1'b0;
      mwr_q  <= 1'b0;
    end
    if (cmd_i.decode) ins_q <= mem_rdata_q;
    if (cmd_i.exec) begin
      st_q    <= x_st;
      wr_q    <= x_wr;
      wi_q    <= x_wr ? x_wi : 5'd0;
      wv_q    <= x_wr ? x_wv : 32'd0;
      tk_q    <= x_tk;
      tg_q    <= x_tg;
      hold_q  <= x_hold;
      mwr_q   <= x_mem && (op == OP_SW || op == OP_SB || op == OP_SH);
      mwidx_q <= ea[MemAw+1:2];
      ea_q    <= ea;
    end
    if (cmd_i.mem) begin
      if (wr_q) wv_q <= ld_val;
      mwdata_q <= st_word;
    end
    if (cmd_i.hdata && st_q == ST_OK) rdword_q <= mem_rdata_q;
    if (cmd_i.commit) begin
      out_q.status          <= st_q;
      out_q.program_counter <= pc_d;
      out_q.reg_write       <= wr_q;
      out_q.reg_index       <= wi_q;
      out_q.reg_value       <= wv_q;
      out_q.read_word       <= rdword_q;
      out_q.hi_value        <= hi_q;
      out_q.lo_value        <= lo_q;
    end
  end

  assign sts_o.kind        = in_data_i.kind;
  assign sts_o.fetch_fault = (word_check(pc_q) != ST_OK);
  assign sts_o.need_mem    = x_mem;
  assign sts_o.is_md       = (op == OP_SPECIAL) && x_md;
  assign sts_o.md_done     = (md_cnt_q == 5'd31);
  assign sts_o.out_busy    = out_valid_i && !out_ready_i;
  assign out_data_o        = out_q;

endmodule

>>> rtl/mips_subset_execute_core.sv
// Top level of the MIPS-I subset execute core: joins sequencer and datapath.
// Depends on mse_pkg, mse_ctrl and mse_dpath.
//
//  channel | signals                         | beat moves
//  in      | in_valid_i in_ready_o in_data_i | kind, byte_address, word_data
//  out     | out_valid_o out_ready_i out_data_o | one result per input beat
//
// One item at a time. An instruction passes fetch, decode and execute, then
// memory for load/store or the 32-step multiply/divide loop, then commit; a
// divide by zero skips the loop. The memory has a single read port.
// Reset clears pc to 0, next pc to 4, HI/LO and register-file valid bits.
// A stalled output beat holds the core in commit until it is taken.
module mips_subset_execute_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  mse_pkg::mse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mse_pkg::mse_out_t out_data_o
);
  import mse_pkg::*;

  mse_cmd_t cmd;
  mse_sts_t sts;

  mse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mse_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

>>> rtl/mse_checker.sv
// Port-level checks for the execute core, bound to the top level.
// Depends on mse_pkg and mips_subset_execute_core.
module mse_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input mse_pkg::mse_in_t  in_data_i,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input mse_pkg::mse_out_t out_data_o
);
  import mse_pkg::*;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("core ready right after accepting a beat");

  a_no_write_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |-> !out_data_o.reg_write)
    else $error("register write reported with error status");

  a_zero_when_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.reg_write |->
      out_data_o.reg_index == 5'd0 && out_data_o.reg_value == 32'd0)
    else $error("register index or value nonzero without write");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  logic unused_in;
  assign unused_in = ^in_data_i;

endmodule

bind mips_subset_execute_core mse_checker u_mse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

>>> sim/mips_subset_execute_core_tb.sv
// Testbench for mips_subset_execute_core: directed and random host and instruction beats,
// each result checked against an in-file model of the core. Depends on mse_pkg and the RTL.
`timescale 1ns / 100ps

module mips_subset_execute_core_tb;
  import mse_pkg::*;

  localparam int unsigned LIMIT = 3_000_000;

  localparam logic [5:0] FN_PICK [21] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_JR,
    FN_MFHI, FN_MFLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU,
    FN_AND, FN_OR, FN_XOR, FN_SLT, FN_SLTU};
  localparam logic [5:0] OP_PICK [20] = '{OP_J, OP_JAL, OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ,
    OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI, OP_XORI, OP_LUI, OP_LB, OP_LW,
    OP_LBU, OP_SB, OP_SH, OP_SW};
  localparam logic [4:0] RT_PICK [4] = '{RT_BLTZ, RT_BGEZ, RT_BLTZAL, RT_BGEZAL};

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  mse_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  mse_out_t out_data_o;

  logic [31:0] gpr [32];
  logic [31:0] hi_m, lo_m, pc_m, npc_m;
  logic [31:0] mem_m [MEM_WORDS];
  bit          mem_set [MEM_WORDS];
  mse_out_t    expected_q [$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          rx_hold = 1'b0;

  mips_subset_execute_core dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic bit addr_in_mem(input logic [31:0] addr);
    return addr[31:2] < 30'(MEM_WORDS);
  endfunction

  function automatic logic [1:0] word_status(input logic [31:0] addr);
    if (addr[1:0] != 2'd0) return ST_ADDR;
    return addr_in_mem(addr) ? ST_OK : ST_RANGE;
  endfunction

  function automatic int unsigned widx(input logic [31:0] addr);
    return int'(addr[MemAw+1:2]);
  endfunction

  function automatic logic [31:0] mk_r(input logic [5:0] fn, input logic [4:0] rs, rt, rd, sa);
    return {OP_SPECIAL, rs, rt, rd, sa, fn};
  endfunction

  function automatic logic [31:0] mk_i(input logic [5:0] op, input logic [4:0] rs, rt,
                                       input logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  task automatic step_core(input mse_in_t it, output mse_out_t res);
    logic [31:0] ins, a, b, imm, simm, ea, boff, r, tgt, wv, rdw, ma, mb, q, m, w;
    logic signed [63:0] sx, sy;
    logic [63:0] p;
    logic [5:0] op, fn;
    logic [4:0] rs, rt, rd, sa, wi;
    logic [1:0] st;
    logic wr, taken, hold;
    int sh;
    st = ST_OK; rdw = '0; wr = 1'b0; wi = '0; wv = '0; taken = 1'b0; hold = 1'b0; tgt = '0;
    case (it.kind)
      KIND_WRITE: begin
        st = word_status(it.byte_address);
        if (st == ST_OK) begin
          mem_m[widx(it.byte_address)] = it.word_data;
          mem_set[widx(it.byte_address)] = 1'b1;
        end
      end
      KIND_READ: begin
        st = word_status(it.byte_address);
        if (st == ST_OK) rdw = mem_m[widx(it.byte_address)];
      end
      KIND_SETPC: begin
        pc_m = it.byte_address;
        npc_m = it.byte_address + 32'd4;
      end
      default: begin
        st = word_status(pc_m);
        if (st == ST_OK) begin
          ins = mem_m[widx(pc_m)];
          op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
          sa = ins[10:6]; fn = ins[5:0];
          imm = {16'h0, ins[15:0]};
          simm = {{16{ins[15]}}, ins[15:0]};
          a = gpr[rs]; b = gpr[rt];
          ea = a + simm;
          boff = npc_m + (simm << 2);
          if (op == OP_SPECIAL) begin
            case (fn)
              FN_SLL:  begin wr = 1; wi = rd; wv = b << sa; end
              FN_SRL:  begin wr = 1; wi = rd; wv = b >> sa; end
              FN_SRA:  begin wr = 1; wi = rd; wv = $unsigned($signed(b) >>> sa); end
              FN_SLLV: begin wr = 1; wi = rd; wv = b << a[4:0]; end
              FN_SRLV: begin wr = 1; wi = rd; wv = b >> a[4:0]; end
              FN_JR: begin
                if (a[1:0] != 2'd0) st = ST_ADDR;
                else begin taken = 1; tgt = a; end
              end
              FN_MFHI: begin wr = 1; wi = rd; wv = hi_m; end
              FN_MFLO: begin wr = 1; wi = rd; wv = lo_m; end
              FN_MULT: begin
                sx = $signed(a); sy = $signed(b);
                p = sx * sy;
                hi_m = p[63:32]; lo_m = p[31:0];
              end
              FN_MULTU: begin
                p = {32'h0, a} * {32'h0, b};
                hi_m = p[63:32]; lo_m = p[31:0];
              end
              FN_DIV: begin
                if (b != 0) begin
                  ma = a[31] ? -a : a;
                  mb = b[31] ? -b : b;
                  q = ma / mb; m = ma % mb;
                  if (a[31] ^ b[31]) q = -q;
                  if (a[31]) m = -m;
                  lo_m = q; hi_m = m;
                end
              end
              FN_DIVU: begin
                if (b != 0) begin lo_m = a / b; hi_m = a % b; end
              end
              FN_ADD: begin
                r = a + b;
                if (a[31] == b[31] && r[31] != a[31]) st = ST_OVF;
                else begin wr = 1; wi = rd; wv = r; end
              end
              FN_SUB: begin
                r = a - b;
                if (a[31] != b[31] && r[31] != a[31]) st = ST_OVF;
                else begin wr = 1; wi = rd; wv = r; end
              end
              FN_ADDU: begin wr = 1; wi = rd; wv = a + b; end
              FN_SUBU: begin wr = 1; wi = rd; wv = a - b; end
              FN_AND:  begin wr = 1; wi = rd; wv = a & b; end
              FN_OR:   begin wr = 1; wi = rd; wv = a | b; end
              FN_XOR:  begin wr = 1; wi = rd; wv = a ^ b; end
              FN_SLT:  begin wr = 1; wi = rd; wv = {31'h0, $signed(a) < $signed(b)}; end
              FN_SLTU: begin wr = 1; wi = rd; wv = {31'h0, a < b}; end
              default: ;
            endcase
          end else if (op == OP_REGIMM) begin
            if (rt == RT_BLTZAL || rt == RT_BGEZAL) begin
              wr = 1; wi = REG_RA; wv = pc_m + 32'd8;
            end
            if (rt == RT_BLTZ || rt == RT_BLTZAL) begin taken = a[31]; tgt = boff; end
            else if (rt == RT_BGEZ || rt == RT_BGEZAL) begin taken = !a[31]; tgt = boff; end
          end else begin
            case (op)
              OP_J, OP_JAL: begin
                if (op == OP_JAL) begin wr = 1; wi = REG_RA; wv = pc_m + 32'd8; end
                taken = 1;
                tgt = {npc_m[31:28], ins[25:0], 2'b00};
              end
              OP_BEQ:  begin taken = (a == b); tgt = boff; end
              OP_BNE:  begin taken = (a != b); tgt = boff; end
              OP_BLEZ: begin taken = a[31] || a == 0; tgt = boff; end
              OP_BGTZ: begin taken = !a[31] && a != 0; tgt = boff; end
              OP_ADDI: begin
                r = a + simm;
                if (a[31] == simm[31] && r[31] != a[31]) st = ST_OVF;
                else begin wr = 1; wi = rt; wv = r; end
              end
              OP_ADDIU: begin wr = 1; wi = rt; wv = a + simm; end
              OP_SLTI:  begin wr = 1; wi = rt; wv = {31'h0, $signed(a) < $signed(simm)}; end
              OP_SLTIU: begin wr = 1; wi = rt; wv = {31'h0, a < simm}; end
              OP_ANDI:  begin wr = 1; wi = rt; wv = a & imm; end
              OP_ORI:   begin wr = 1; wi = rt; wv = a | imm; end
              OP_XORI:  begin wr = 1; wi = rt; wv = a ^ imm; end
              OP_LUI:   begin wr = 1; wi = rt; wv = imm << 16; end
              OP_LW: begin
                st = word_status(ea);
                if (st == ST_OK) begin wr = 1; wi = rt; wv = mem_m[widx(ea)]; end
              end
              OP_LB, OP_LBU: begin
                st = addr_in_mem(ea) ? ST_OK : ST_RANGE;
                if (st == ST_OK) begin
                  sh = (3 - int'(ea[1:0])) * 8;
                  wv = (mem_m[widx(ea)] >> sh) & 32'hFF;
                  if (op == OP_LB && wv[7]) wv |= 32'hFFFFFF00;
                  wr = 1; wi = rt;
                end
              end
              OP_SW: begin
                st = word_status(ea);
                if (st == ST_ADDR) hold = 1;
                else if (st == ST_OK) begin
                  mem_m[widx(ea)] = b;
                  mem_set[widx(ea)] = 1'b1;
                end
              end
              OP_SB: begin
                st = addr_in_mem(ea) ? ST_OK : ST_RANGE;
                if (st == ST_OK) begin
                  sh = (3 - int'(ea[1:0])) * 8;
                  w = mem_m[widx(ea)];
                  mem_m[widx(ea)] = (w & ~(32'hFF << sh)) | ((b & 32'hFF) << sh);
                end
              end
              OP_SH: begin
                if (ea[0]) begin st = ST_ADDR; hold = 1; end
                else begin
                  st = addr_in_mem(ea) ? ST_OK : ST_RANGE;
                  if (st == ST_OK) begin
                    sh = ea[1] ? 0 : 16;
                    w = mem_m[widx(ea)];
                    mem_m[widx(ea)] = (w & ~(32'hFFFF << sh)) | ((b & 32'hFFFF) << sh);
                  end
                end
              end
              default: ;
            endcase
          end
          if (st != ST_OK || wi == 5'd0) wr = 0;
          if (wr) gpr[wi] = wv;
          else begin wi = '0; wv = '0; end
        end
        if (!hold) begin
          pc_m = npc_m;
          npc_m = taken ? tgt : pc_m + 32'd4;
        end
      end
    endcase
    res.status = st;
    res.program_counter = pc_m;
    res.reg_write = wr;
    res.reg_index = wi;
    res.reg_value = wv;
    res.read_word = rdw;
    res.hi_value = hi_m;
    res.lo_value = lo_m;
  endtask

  task automatic send_beat(input logic [1:0] kind, input logic [31:0] addr, data);
    mse_in_t  it;
    mse_out_t res;
    it.kind = kind; it.byte_address = addr; it.word_data = data;
    if (tx_gaps && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    step_core(it, res);
    expected_q.push_back(res);
  endtask

  task automatic stop_beats();
    in_valid_i <= 1'b0;
  endtask

  task automatic drain();
    stop_beats();
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
  endtask

  // write the word at pc if fresh or unwritten, back any unwritten memory word the access reads, then execute
  task automatic run_ins(input bit fresh, input logic [31:0] ins);
    logic [31:0] cur, ea;
    logic [5:0] op;
    bit reads;
    if (word_status(pc_m) == ST_OK) begin
      if (fresh || !mem_set[widx(pc_m)]) send_beat(KIND_WRITE, pc_m, ins);
      cur = mem_m[widx(pc_m)];
      op = cur[31:26];
      ea = gpr[cur[25:21]] + {{16{cur[15]}}, cur[15:0]};
      reads = 1'b0;
      if (op == OP_LB || op == OP_LBU || op == OP_SB) reads = addr_in_mem(ea);
      if (op == OP_LW) reads = (word_status(ea) == ST_OK);
      if (op == OP_SH) reads = !ea[0] && addr_in_mem(ea);
      if (reads && !mem_set[widx(ea)]) send_beat(KIND_WRITE, {ea[31:2], 2'b00}, $urandom);
    end
    send_beat(KIND_EXEC, $urandom, $urandom);
  endtask

  function automatic logic [31:0] rand_ins();
    logic [31:0] ins;
    int k;
    ins = $urandom;
    k = $urandom_range(0, 29);
    if (k < 12) begin
      ins[31:26] = OP_SPECIAL;
      ins[5:0] = ($urandom_range(0, 19) == 0) ? 6'($urandom) : FN_PICK[$urandom_range(0, 20)];
    end else if (k < 14) begin
      ins[31:26] = OP_REGIMM;
      if ($urandom_range(0, 9) != 0) ins[20:16] = RT_PICK[$urandom_range(0, 3)];
    end else begin
      ins[31:26] = ($urandom_range(0, 19) == 0) ? 6'($urandom) : OP_PICK[$urandom_range(0, 19)];
    end
    case (ins[31:26])
      OP_LB, OP_LW, OP_LBU, OP_SB, OP_SH, OP_SW:
        if ($urandom_range(0, 9) < 7) begin
          ins[25:21] = '0;
          ins[15:0] = 16'($urandom_range(0, MEM_WORDS * 4 - 1));
          if (ins[31:26] != OP_LB && ins[31:26] != OP_LBU && ins[31:26] != OP_SB &&
              $urandom_range(0, 3) != 0) ins[1:0] = 2'b00;
        end
      OP_J, OP_JAL:
        if ($urandom_range(0, 9) < 8) ins[25:12] = '0;
      OP_BEQ, OP_BNE, OP_BLEZ, OP_BGTZ, OP_REGIMM:
        if ($urandom_range(0, 9) < 8) ins[15:0] = 16'($urandom_range(0, 127) - 64);
      default: ;
    endcase
    return ins;
  endfunction

  task automatic random_item();
    logic [31:0] addr;
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      send_beat(KIND_WRITE, ($urandom_range(0, 1) != 0) ? $urandom
                : 32'($urandom_range(0, MEM_WORDS - 1) * 4), $urandom);
    end else if (r < 8) begin
      addr = ($urandom_range(0, 2) == 0) ? $urandom
             : 32'($urandom_range(0, MEM_WORDS - 1) * 4);
      if (word_status(addr) == ST_OK && !mem_set[widx(addr)])
        send_beat(KIND_WRITE, addr, $urandom);
      else send_beat(KIND_READ, addr, $urandom);
    end else if (r < 10) begin
      send_beat(KIND_SETPC, $urandom, $urandom);
    end else if (word_status(pc_m) != ST_OK && $urandom_range(0, 9) < 7) begin
      send_beat(KIND_SETPC, 32'($urandom_range(0, 255) * 4), $urandom);
    end else begin
      run_ins($urandom_range(0, 3) != 0, rand_ins());
    end
  endtask

  task automatic test_host_beats();
    send_beat(KIND_WRITE, 32'h0, 32'hFFFFFFFF);
    send_beat(KIND_READ, 32'h0, 32'h0);
    send_beat(KIND_READ, 32'h2, 32'h0);
    send_beat(KIND_WRITE, 32'hFFFFFFFC, 32'h0);
    send_beat(KIND_WRITE, MEM_WORDS * 4 - 4, 32'h80000001);
    send_beat(KIND_READ, MEM_WORDS * 4 - 4, 32'h0);
    send_beat(KIND_SETPC, 32'h100, 32'h0);
  endtask

  task automatic test_directed_ins();
    run_ins(1, mk_i(OP_LUI, 5'd0, 5'd1, 16'h8000));
    run_ins(1, mk_i(OP_ADDIU, 5'd0, 5'd2, 16'hFFFF));
    run_ins(1, mk_r(FN_ADD, 5'd1, 5'd2, 5'd3, 5'd0));
    run_ins(1, mk_r(FN_SRA, 5'd0, 5'd1, 5'd4, 5'd31));
    run_ins(1, mk_r(FN_DIV, 5'd1, 5'd2, 5'd0, 5'd0));
    run_ins(1, mk_r(FN_DIV, 5'd1, 5'd0, 5'd0, 5'd0));
    run_ins(1, mk_r(FN_MULT, 5'd1, 5'd2, 5'd0, 5'd0));
    run_ins(1, mk_r(FN_MFHI, 5'd0, 5'd0, 5'd5, 5'd0));
    run_ins(1, mk_r(FN_MFLO, 5'd0, 5'd0, 5'd6, 5'd0));
    run_ins(1, mk_r(FN_ADDU, 5'd2, 5'd2, 5'd0, 5'd0));
    run_ins(1, mk_i(OP_SW, 5'd0, 5'd2, 16'h0002));
    run_ins(1, mk_i(OP_LW, 5'd0, 5'd7, 16'h0000));
    run_ins(1, mk_r(FN_JR, 5'd2, 5'd0, 5'd0, 5'd0));
    run_ins(1, mk_r(6'd1, 5'd1, 5'd2, 5'd9, 5'd0));
    run_ins(1, mk_i(OP_BEQ, 5'd0, 5'd0, 16'h0004));
    run_ins(1, mk_i(OP_SB, 5'd0, 5'd2, 16'h0001));
    run_ins(1, {OP_JAL, 26'h40});
    run_ins(1, mk_i(OP_SH, 5'd0, 5'd2, 16'h0003));
    run_ins(1, mk_i(OP_LB, 5'd0, 5'd8, 16'h0001));
    run_ins(1, mk_i(OP_REGIMM, 5'd1, RT_BGEZAL, 16'h0010));
    send_beat(KIND_SETPC, 32'h2, 32'h0);
    run_ins(1, 32'h0);
    send_beat(KIND_SETPC, 32'hFFFFFFF0, 32'h0);
    run_ins(1, 32'h0);
    send_beat(KIND_SETPC, 32'h0, 32'h0);
  endtask

  task automatic test_random_items(input int n);
    repeat (n) random_item();
  endtask

  task automatic test_output_backpressure();
    rx_hold = 1'b1;
    tx_gaps = 1'b0;
    repeat (40) random_item();
    tx_gaps = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < 32; i++) gpr[i] = '0;
    hi_m = '0; lo_m = '0; pc_m = 32'h0; npc_m = 32'h4;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_host_beats();
    test_directed_ins();
    test_random_items(450);
    test_output_backpressure();
    test_random_items(400);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    test_random_items(150);
    drain();
    repeat (60) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    forever begin
      if (rx_hold) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        rx_hold = 1'b0;
      end else if (!rx_gaps || $urandom_range(0, 1) != 0) begin
        out_ready_i <= 1'b1;
        repeat (rx_gaps ? $urandom_range(1, 20) : 1) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    mse_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat: %p", out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d pc=%h w=%b i=%0d v=%h rd=%h hi=%h lo=%h\n%s%0d pc=%h w=%b i=%0d v=%h rd=%h hi=%h lo=%h",
                     want.status, want.program_counter, want.reg_write, want.reg_index,
                     want.reg_value, want.read_word, want.hi_value, want.lo_value,
                     "          got st=", out_data_o.status, out_data_o.program_counter,
                     out_data_o.reg_write, out_data_o.reg_index, out_data_o.reg_value,
                     out_data_o.read_word, out_data_o.hi_value, out_data_o.lo_value);
        end
      end
    end
  end

endmodule
